>>> rtl/tslf_pkg.sv
// ----------------------------------------------------------------------------
// tslf_pkg: shared types and constants of the text stream line formatter
// Character codes, register indexes, numbering modes and the job record
// that travels from the front part to the back part through the queue.
// ----------------------------------------------------------------------------
package tslf_pkg;

  // Default number of BCD digits in the line counter.
  localparam int DIGITS_DEF = 10;

  // Field width of a printed line number, and the pad counter width.
  localparam int NUM_WIDTH = 6;
  localparam int PADW      = $clog2(NUM_WIDTH);

  // Depth of the job queue between front and back.
  localparam int QDEPTH = 2;

  // Configuration port widths.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 2;

  // Register indexes.
  localparam logic [CFG_AW-1:0] REG_NUMBERING = 3'd0;
  localparam logic [CFG_AW-1:0] REG_LINE_ENDS = 3'd1;
  localparam logic [CFG_AW-1:0] REG_SQUEEZE   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_TABS      = 3'd3;
  localparam logic [CFG_AW-1:0] REG_CARET     = 3'd4;

  // Numbering modes.
  localparam logic [1:0] MODE_ALL      = 2'd1;
  localparam logic [1:0] MODE_NONBLANK = 2'd2;

  // Character codes.
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_DOLLAR   = 8'h24;
  localparam logic [7:0] CH_DASH     = 8'h2D;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_CTRL_OFS = 8'h40;
  localparam logic [7:0] CH_I        = 8'h49;
  localparam logic [7:0] CH_M        = 8'h4D;
  localparam logic [7:0] CH_CARET    = 8'h5E;
  localparam logic [7:0] CH_DEL      = 8'h7F;
  localparam logic [7:0] CH_CTRL_END = 8'h20;

  // Configuration register set.
  typedef struct packed {
    logic [1:0] numbering_mode;
    logic       show_line_ends;
    logic       squeeze_blank_lines;
    logic       show_tabs_caret;
    logic       caret_notation;
  } cfg_t;

  // Control part of a job: optional line number, then one to four body bytes.
  typedef struct packed {
    logic            has_num;
    logic [1:0]      body_last;
    logic [3:0][7:0] body;
  } job_ctl_t;

endpackage

>>> rtl/tslf_front.sv
// ----------------------------------------------------------------------------
// tslf_front: item acceptance and classification
// Accepts input items, keeps the line state and the BCD line counter, and
// turns each item into a job record for the back part.
// ----------------------------------------------------------------------------
module tslf_front #(
  parameter int DIGITS = tslf_pkg::DIGITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  tslf_pkg::cfg_t           cfg,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_byte,
  input  logic                     in_eos,
  input  logic                     q_full,
  output logic                     push,
  output tslf_pkg::job_ctl_t       push_ctl,
  output logic [DIGITS-1:0][3:0]   push_bcd
);

  logic                   has_content;
  logic                   prev_blank;
  logic [DIGITS-1:0][3:0] bcd;
  logic [DIGITS-1:0][3:0] bcd_inc;

  logic accept;
  logic is_nl;
  logic is_tab;
  logic blank;
  logic squeezed;
  logic need_num;
  logic carry;
  logic [7:0] e0;
  logic [7:0] e1;
  logic       two;
  logic [6:0] low;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;

  // Classification of the byte and the line state.
  always_comb begin
    is_nl    = (in_byte == tslf_pkg::CH_NL);
    is_tab   = (in_byte == tslf_pkg::CH_TAB);
    blank    = !has_content;
    squeezed = is_nl && cfg.squeeze_blank_lines && blank && prev_blank;
    if (is_nl) begin
      need_num = blank && (cfg.numbering_mode == tslf_pkg::MODE_ALL);
    end else begin
      need_num = !has_content && (cfg.numbering_mode == tslf_pkg::MODE_ALL ||
                                  cfg.numbering_mode == tslf_pkg::MODE_NONBLANK);
    end
    push = accept && !in_eos && !squeezed;
  end

  // BCD increment: a digit steps when every lower digit is nine.
  always_comb begin
    carry = 1'b1;
    for (int i = 0; i < DIGITS; i++) begin
      if (carry) begin
        bcd_inc[i] = (bcd[i] >= 4'd9) ? 4'd0 : bcd[i] + 4'd1;
      end else begin
        bcd_inc[i] = bcd[i];
      end
      carry = carry && (bcd[i] >= 4'd9);
    end
  end

  // Caret expansion of the low seven bits.
  always_comb begin
    low = in_byte[6:0];
    e1  = '0;
    two = 1'b0;
    if ({1'b0, low} < tslf_pkg::CH_CTRL_END) begin
      e0  = tslf_pkg::CH_CARET;
      e1  = {1'b0, low} + tslf_pkg::CH_CTRL_OFS;
      two = 1'b1;
    end else if ({1'b0, low} == tslf_pkg::CH_DEL) begin
      e0  = tslf_pkg::CH_CARET;
      e1  = tslf_pkg::CH_QUESTION;
      two = 1'b1;
    end else begin
      e0 = {1'b0, low};
    end
  end

  // Body bytes of the job.
  always_comb begin
    push_ctl           = '0;
    push_ctl.has_num   = need_num;
    push_bcd           = bcd_inc;
    if (is_nl) begin
      if (cfg.show_line_ends) begin
        push_ctl.body[0]   = tslf_pkg::CH_DOLLAR;
        push_ctl.body[1]   = tslf_pkg::CH_NL;
        push_ctl.body_last = 2'd1;
      end else begin
        push_ctl.body[0]   = tslf_pkg::CH_NL;
      end
    end else if (is_tab && cfg.show_tabs_caret) begin
      push_ctl.body[0]   = tslf_pkg::CH_CARET;
      push_ctl.body[1]   = tslf_pkg::CH_I;
      push_ctl.body_last = 2'd1;
    end else if (cfg.caret_notation && !is_tab) begin
      if (in_byte[7]) begin
        push_ctl.body[0]   = tslf_pkg::CH_M;
        push_ctl.body[1]   = tslf_pkg::CH_DASH;
        push_ctl.body[2]   = e0;
        push_ctl.body[3]   = e1;
        push_ctl.body_last = two ? 2'd3 : 2'd2;
      end else begin
        push_ctl.body[0]   = e0;
        push_ctl.body[1]   = e1;
        push_ctl.body_last = two ? 2'd1 : 2'd0;
      end
    end else begin
      push_ctl.body[0] = in_byte;
    end
  end

  // Line state and counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      has_content <= 1'b0;
      prev_blank  <= 1'b0;
      bcd         <= '0;
    end else if (accept) begin
      if (in_eos) begin
        has_content <= 1'b0;
      end else if (is_nl) begin
        if (!squeezed) begin
          prev_blank  <= blank;
          has_content <= 1'b0;
        end
      end else begin
        has_content <= 1'b1;
      end
      if (push && need_num) begin
        bcd <= bcd_inc;
      end
    end
  end

endmodule

>>> rtl/tslf_queue.sv
// ----------------------------------------------------------------------------
// tslf_queue: short job queue
// A small first-in first-out queue with the head entry shown ahead, so the
// front and the back part can stall independently.
// ----------------------------------------------------------------------------
module tslf_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty,
  output logic             full
);

  localparam int PW = $clog2(tslf_pkg::QDEPTH);
  localparam int CW = $clog2(tslf_pkg::QDEPTH + 1);

  logic [WIDTH-1:0] store [tslf_pkg::QDEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign empty = (count == '0);
  assign full  = (count == CW'(tslf_pkg::QDEPTH));
  assign head  = store[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(tslf_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(tslf_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/tslf_back.sv
// ----------------------------------------------------------------------------
// tslf_back: job expansion and output register
// Takes jobs from the queue and emits padding, number digits, tab and body
// bytes one per cycle, while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module tslf_back #(
  parameter int DIGITS = tslf_pkg::DIGITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_empty,
  input  tslf_pkg::job_ctl_t     head_ctl,
  input  logic [DIGITS-1:0][3:0] head_bcd,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_byte,
  output logic                   out_last
);

  localparam int IDXW = $clog2(DIGITS);

  typedef enum logic [3:0] {
    PH_PAD  = 4'b0001,
    PH_DIG  = 4'b0010,
    PH_TAB  = 4'b0100,
    PH_BODY = 4'b1000
  } phase_t;

  logic                    job_valid;
  phase_t                  phase;
  logic [tslf_pkg::PADW-1:0] pad_cnt;
  logic [IDXW-1:0]         dig_idx;
  logic [1:0]              body_idx;
  tslf_pkg::job_ctl_t      ctl;
  logic [DIGITS-1:0][3:0]  bcd;

  logic       step;
  logic       is_last;
  logic [7:0] cur_byte;
  logic [IDXW-1:0] top;

  // Highest non-zero digit of the head entry (digit zero at least).
  always_comb begin
    top = '0;
    for (int i = 1; i < DIGITS; i++) begin
      if (head_bcd[i] != 4'd0) begin
        top = IDXW'(i);
      end
    end
  end

  // Byte of the current position.
  always_comb begin
    is_last = 1'b0;
    case (phase)
      PH_PAD:  cur_byte = tslf_pkg::CH_SPACE;
      PH_DIG:  cur_byte = tslf_pkg::CH_ZERO + {4'd0, bcd[dig_idx]};
      PH_TAB:  cur_byte = tslf_pkg::CH_TAB;
      PH_BODY: begin
        cur_byte = ctl.body[body_idx];
        is_last  = (body_idx == ctl.body_last);
      end
      default: cur_byte = tslf_pkg::CH_SPACE;
    endcase
  end

  assign step = job_valid && (!out_valid || out_ready);
  assign pop  = !q_empty && (!job_valid || (step && is_last));

  // Sequencer over the positions of a job.
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      phase     <= PH_BODY;
    end else if (pop) begin
      job_valid <= 1'b1;
      ctl       <= head_ctl;
      bcd       <= head_bcd;
      body_idx  <= '0;
      dig_idx   <= top;
      pad_cnt   <= tslf_pkg::PADW'(tslf_pkg::NUM_WIDTH - 1) - tslf_pkg::PADW'(top);
      if (!head_ctl.has_num) begin
        phase <= PH_BODY;
      end else if (top < IDXW'(tslf_pkg::NUM_WIDTH - 1)) begin
        phase <= PH_PAD;
      end else begin
        phase <= PH_DIG;
      end
    end else if (step) begin
      case (phase)
        PH_PAD: begin
          pad_cnt <= pad_cnt - 1'b1;
          if (pad_cnt == tslf_pkg::PADW'(1)) begin
            phase <= PH_DIG;
          end
        end
        PH_DIG: begin
          dig_idx <= dig_idx - 1'b1;
          if (dig_idx == '0) begin
            phase <= PH_TAB;
          end
        end
        PH_TAB: phase <= PH_BODY;
        PH_BODY: begin
          body_idx <= body_idx + 1'b1;
          if (is_last) begin
            job_valid <= 1'b0;
          end
        end
        default: phase <= PH_BODY;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_byte <= cur_byte;
      out_last <= is_last;
    end
  end

endmodule

>>> rtl/text_stream_line_formatter_top.sv
// ----------------------------------------------------------------------------
// text_stream_line_formatter_top: byte stream line formatter
// Reformats a text byte stream with optional line numbers, caret notation,
// visible tabs, visible line ends and squeezing of repeated blank lines.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one input item per byte; s_tlast marks the end of
//   an input file instead of a byte and closes any unfinished line.
//   The m_ channel returns the formatted bytes; m_tlast is set on the last
//   byte caused by an input item. Items that cause no bytes (end of file,
//   a squeezed blank line) produce nothing on m_.
//   Configuration registers are written through cfg_wr_en, cfg_addr and
//   cfg_wdata while the block is idle, a rule on the user that the block does not check.
// Timing:
//   The first output byte of an item passes through the queue entry, the
//   back part's job register and the output register. While m_tready is
//   high the back part emits one output byte per cycle and plain bytes flow
//   at one item per cycle; an item has one to 15 output bytes (ten digits).
// Reset and stalls:
//   rst clears the configuration, the line counter and the line state.
//   When m_tready is low the output register holds its byte; the job queue
//   keeps taking items until it is full, then s_tready drops.
// ----------------------------------------------------------------------------
module text_stream_line_formatter_top #(
  parameter int DIGITS = tslf_pkg::DIGITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // Configuration write port
  input  logic                        cfg_wr_en,
  input  logic [tslf_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [tslf_pkg::CFG_DW-1:0] cfg_wdata,
  // Input stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // [7:0] data_byte
  input  logic                        s_tlast,   // end_of_stream
  // Output stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [7:0]                  m_tdata,   // [7:0] out_byte
  output logic                        m_tlast    // last_of_run
);

  localparam int CTLW = $bits(tslf_pkg::job_ctl_t);
  localparam int JOBW = CTLW + DIGITS * 4;

  tslf_pkg::cfg_t         cfg;
  logic                   push;
  tslf_pkg::job_ctl_t     push_ctl;
  logic [DIGITS-1:0][3:0] push_bcd;
  logic                   pop;
  logic                   q_empty;
  logic                   q_full;
  logic [JOBW-1:0]        head;
  tslf_pkg::job_ctl_t     head_ctl;
  logic [DIGITS-1:0][3:0] head_bcd;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        tslf_pkg::REG_NUMBERING: cfg.numbering_mode      <= cfg_wdata;
        tslf_pkg::REG_LINE_ENDS: cfg.show_line_ends      <= cfg_wdata[0];
        tslf_pkg::REG_SQUEEZE:   cfg.squeeze_blank_lines <= cfg_wdata[0];
        tslf_pkg::REG_TABS:      cfg.show_tabs_caret     <= cfg_wdata[0];
        tslf_pkg::REG_CARET:     cfg.caret_notation      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  tslf_front #(.DIGITS(DIGITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .in_eos   (s_tlast),
    .q_full   (q_full),
    .push     (push),
    .push_ctl (push_ctl),
    .push_bcd (push_bcd)
  );

  tslf_queue #(.WIDTH(JOBW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_ctl, push_bcd}),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  assign head_ctl = head[JOBW-1 -: CTLW];
  assign head_bcd = head[DIGITS*4-1:0];

  tslf_back #(.DIGITS(DIGITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head_ctl  (head_ctl),
    .head_bcd  (head_bcd),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

>>> verif/tb_text_stream_line_formatter_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_stream_line_formatter_top: self-checking bench of the line formatter
// A short table of directed items runs first. Some rows carry their output
// bytes written out by hand, and the rest are checked against a behavioural
// formatter kept in the bench. Random text follows in phases with different
// register settings and idle cycles on none, one or both sides. Every output
// item is compared with the oldest predicted byte and its last flag.
// ----------------------------------------------------------------------------
module tb_text_stream_line_formatter_top;

  localparam int NDIG        = tslf_pkg::DIGITS_DEF;
  localparam int SETTLE      = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 18;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  // One row of the directed plan: a register write or an input item,
  // optionally with its output bytes written out (first byte lowest).
  typedef struct packed {
    row_kind_t                   kind;
    logic [tslf_pkg::CFG_AW-1:0] idx;
    logic [tslf_pkg::CFG_DW-1:0] val;
    logic [7:0]                  data;
    logic                        eos;
    logic                        fixed;
    logic [2:0]                  fixed_n;
    logic [31:0]                 fixed_bytes;
  } plan_row_t;

  logic                        clk;
  logic                        rst;
  logic                        cfg_wr_en;
  logic [tslf_pkg::CFG_AW-1:0] cfg_addr;
  logic [tslf_pkg::CFG_DW-1:0] cfg_wdata;
  logic                        s_tvalid;
  logic                        s_tready;
  logic [7:0]                  s_tdata;   // [7:0] data_byte
  logic                        s_tlast;   // end_of_stream
  logic                        m_tvalid;
  logic                        m_tready;
  logic [7:0]                  m_tdata;   // [7:0] out_byte
  logic                        m_tlast;   // last_of_run

  // Hand-written output bytes that travel alongside the current item.
  logic        cur_fixed;
  logic [2:0]  cur_fixed_n;
  logic [31:0] cur_fixed_bytes;

  // Shadow of the registers and of the line state.
  tslf_pkg::cfg_t shadow_cfg;
  logic [3:0]     line_no [NDIG];
  logic           has_text;
  logic           last_blank;

  logic [7:0] fmt_bytes [$];
  logic [8:0] pending_out [$];   // {last_of_run, out_byte}
  plan_row_t  plan [$];

  int src_idle_pct;
  int rcv_stall_pct;
  int cycles;
  int mismatches;
  int items_sent;
  int bytes_checked;

  text_stream_line_formatter_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always #4 clk = ~clk;

  // Receiver: ready is redrawn at every falling edge.
  always @(negedge clk) begin
    if (rcv_stall_pct == 0) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end
  end

  // Append one byte to the formatted output of the current item.
  function automatic void put_byte(input logic [7:0] b);
    fmt_bytes = {fmt_bytes, b};
  endfunction

  // Append one predicted output item to the list of those still due.
  function automatic void add_due(input logic [8:0] e);
    pending_out = {pending_out, e};
  endfunction

  // Increment the BCD line counter and append the padded number and a tab.
  task automatic emit_line_no();
    logic carry;
    int   top;
    carry = 1'b1;
    for (int i = 0; i < NDIG; i++) begin
      if (carry) begin
        if (line_no[i] == 4'd9) begin
          line_no[i] = 4'd0;
        end else begin
          line_no[i] = line_no[i] + 4'd1;
          carry = 1'b0;
        end
      end
    end
    top = 0;
    for (int i = NDIG - 1; i > 0; i--) begin
      if (top == 0 && line_no[i] != 4'd0) top = i;
    end
    for (int i = top + 1; i < tslf_pkg::NUM_WIDTH; i++) put_byte(tslf_pkg::CH_SPACE);
    for (int i = top; i >= 0; i--) put_byte(tslf_pkg::CH_ZERO + 8'(line_no[i]));
    put_byte(tslf_pkg::CH_TAB);
  endtask

  // Seven-bit character in caret notation.
  task automatic emit_low7(input logic [7:0] c);
    if (c < tslf_pkg::CH_CTRL_END) begin
      put_byte(tslf_pkg::CH_CARET);
      put_byte(c + tslf_pkg::CH_CTRL_OFS);
    end else if (c == tslf_pkg::CH_DEL) begin
      put_byte(tslf_pkg::CH_CARET);
      put_byte(tslf_pkg::CH_QUESTION);
    end else begin
      put_byte(c);
    end
  endtask

  // Formatted bytes of one input item; updates the line state.
  task automatic format_item(input logic [7:0] c, input logic eos);
    logic blank;
    fmt_bytes.delete();
    if (eos) begin
      has_text = 1'b0;
      return;
    end
    if (c == tslf_pkg::CH_NL) begin
      blank = !has_text;
      if (shadow_cfg.squeeze_blank_lines && blank && last_blank) return;
      last_blank = blank;
      if (blank && shadow_cfg.numbering_mode == tslf_pkg::MODE_ALL) emit_line_no();
      if (shadow_cfg.show_line_ends) put_byte(tslf_pkg::CH_DOLLAR);
      put_byte(tslf_pkg::CH_NL);
      has_text = 1'b0;
    end else begin
      if (!has_text && (shadow_cfg.numbering_mode == tslf_pkg::MODE_ALL ||
                        shadow_cfg.numbering_mode == tslf_pkg::MODE_NONBLANK)) begin
        emit_line_no();
      end
      has_text = 1'b1;
      if (c == tslf_pkg::CH_TAB && shadow_cfg.show_tabs_caret) begin
        put_byte(tslf_pkg::CH_CARET);
        put_byte(tslf_pkg::CH_I);
      end else if (shadow_cfg.caret_notation && c != tslf_pkg::CH_TAB) begin
        if (c[7]) begin
          put_byte(tslf_pkg::CH_M);
          put_byte(tslf_pkg::CH_DASH);
          emit_low7({1'b0, c[6:0]});
        end else begin
          emit_low7(c);
        end
      end else begin
        put_byte(c);
      end
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [8:0] want,
                               input logic [8:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s) at cycle %0d: want byte %02h last %0b, got byte %02h last %0b",
               what, cycles, want[7:0], want[8], got[7:0], got[8]);
    end
  endtask

  // Scoreboard: register shadow, prediction on acceptance, output check.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout with %0d output items still due", pending_out.size());
      $display("tb_text_stream_line_formatter_top: FAIL");
      $finish;
    end else if (!rst) begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          tslf_pkg::REG_NUMBERING: shadow_cfg.numbering_mode      <= cfg_wdata[1:0];
          tslf_pkg::REG_LINE_ENDS: shadow_cfg.show_line_ends      <= cfg_wdata[0];
          tslf_pkg::REG_SQUEEZE:   shadow_cfg.squeeze_blank_lines <= cfg_wdata[0];
          tslf_pkg::REG_TABS:      shadow_cfg.show_tabs_caret     <= cfg_wdata[0];
          tslf_pkg::REG_CARET:     shadow_cfg.caret_notation      <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        format_item(s_tdata, s_tlast);
        if (cur_fixed) begin
          fmt_bytes.delete();
          for (int i = 0; i < cur_fixed_n; i++) put_byte(cur_fixed_bytes[8*i +: 8]);
        end
        foreach (fmt_bytes[i]) begin
          add_due({i == fmt_bytes.size() - 1, fmt_bytes[i]});
        end
      end
      if (m_tvalid && m_tready) begin
        bytes_checked++;
        if (pending_out.size() == 0) begin
          flag_mismatch("no item was due", 9'h000, {m_tlast, m_tdata});
        end else if (pending_out[0] !== {m_tlast, m_tdata}) begin
          flag_mismatch("wrong field", pending_out[0], {m_tlast, m_tdata});
          void'(pending_out.pop_front());
        end else begin
          void'(pending_out.pop_front());
        end
      end
    end
  end

  // Present one item at a falling edge and hold it until it is taken.
  task automatic send_item(input logic [7:0] d, input logic eos, input logic fixed,
                           input logic [2:0] fixed_n, input logic [31:0] fixed_bytes);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid        <= 1'b1;
    s_tdata         <= d;
    s_tlast         <= eos;
    cur_fixed       <= fixed;
    cur_fixed_n     <= fixed_n;
    cur_fixed_bytes <= fixed_bytes;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    @(negedge clk);
  endtask

  // Let every due output arrive, then give items with no output time to pass.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_out.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [tslf_pkg::CFG_AW-1:0] idx,
                           input logic [tslf_pkg::CFG_DW-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_all(input logic [1:0] mode, input logic [1:0] ends,
                         input logic [1:0] squeeze, input logic [1:0] tabs,
                         input logic [1:0] caret);
    write_reg(tslf_pkg::REG_NUMBERING, mode);
    write_reg(tslf_pkg::REG_LINE_ENDS, ends);
    write_reg(tslf_pkg::REG_SQUEEZE, squeeze);
    write_reg(tslf_pkg::REG_TABS, tabs);
    write_reg(tslf_pkg::REG_CARET, caret);
  endtask

  function automatic void add_item(input logic [7:0] d, input logic eos);
    plan_row_t row;
    row  = '{ROW_ITEM, '0, '0, d, eos, 1'b0, 3'd0, 32'h0};
    plan = {plan, row};
  endfunction

  function automatic void add_fixed(input logic [7:0] d, input logic eos,
                                    input logic [2:0] n, input logic [31:0] w);
    plan_row_t row;
    row  = '{ROW_ITEM, '0, '0, d, eos, 1'b1, n, w};
    plan = {plan, row};
  endfunction

  function automatic void add_reg(input logic [tslf_pkg::CFG_AW-1:0] idx,
                                  input logic [tslf_pkg::CFG_DW-1:0] v);
    plan_row_t row;
    row  = '{ROW_REG, idx, v, 8'h00, 1'b0, 1'b0, 3'd0, 32'h0};
    plan = {plan, row};
  endfunction

  initial begin
    plan_row_t  row;
    int         r;
    logic [7:0] b;
    logic       eos;

    clk = 1'b0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = 8'h00;
    s_tlast = 1'b0;
    m_tready = 1'b0;
    cur_fixed = 1'b0;
    cur_fixed_n = 3'd0;
    cur_fixed_bytes = 32'h0;
    shadow_cfg = '0;
    foreach (line_no[i]) line_no[i] = 4'd0;
    has_text = 1'b0;
    last_blank = 1'b0;
    src_idle_pct = 0;
    rcv_stall_pct = 0;
    cycles = 0;
    mismatches = 0;
    items_sent = 0;
    bytes_checked = 0;

    // Registers at reset: every byte passes through unchanged.
    add_fixed(8'h61, 1'b0, 3'd1, {24'h0, 8'h61});
    add_fixed(8'h00, 1'b0, 3'd1, {24'h0, 8'h00});
    add_fixed(8'hFF, 1'b0, 3'd1, {24'h0, 8'hFF});
    add_fixed(tslf_pkg::CH_NL, 1'b0, 3'd1, {24'h0, tslf_pkg::CH_NL});
    add_fixed(tslf_pkg::CH_NL, 1'b0, 3'd1, {24'h0, tslf_pkg::CH_NL});
    // Everything on: numbers on all lines, caret forms, line ends, squeezing.
    add_reg(tslf_pkg::REG_CARET, 2'd1);
    add_reg(tslf_pkg::REG_TABS, 2'd1);
    add_reg(tslf_pkg::REG_LINE_ENDS, 2'd1);
    add_reg(tslf_pkg::REG_SQUEEZE, 2'd1);
    add_reg(tslf_pkg::REG_NUMBERING, tslf_pkg::MODE_ALL);
    add_item(8'h00, 1'b0);
    add_fixed(tslf_pkg::CH_DEL, 1'b0, 3'd2,
              {16'h0, tslf_pkg::CH_QUESTION, tslf_pkg::CH_CARET});
    add_fixed(8'h80, 1'b0, 3'd4,
              {tslf_pkg::CH_CTRL_OFS, tslf_pkg::CH_CARET, tslf_pkg::CH_DASH, tslf_pkg::CH_M});
    add_fixed(8'hFF, 1'b0, 3'd4,
              {tslf_pkg::CH_QUESTION, tslf_pkg::CH_CARET, tslf_pkg::CH_DASH, tslf_pkg::CH_M});
    add_fixed(tslf_pkg::CH_TAB, 1'b0, 3'd2, {16'h0, tslf_pkg::CH_I, tslf_pkg::CH_CARET});
    add_fixed(8'h1F, 1'b0, 3'd2, {16'h0, 8'h5F, tslf_pkg::CH_CARET});
    add_fixed(tslf_pkg::CH_NL, 1'b0, 3'd2, {16'h0, tslf_pkg::CH_NL, tslf_pkg::CH_DOLLAR});
    add_item(tslf_pkg::CH_NL, 1'b0);
    // A second blank line in a row is dropped, and end of stream is silent.
    add_fixed(tslf_pkg::CH_NL, 1'b0, 3'd0, 32'h0);
    add_fixed(8'hA5, 1'b1, 3'd0, 32'h0);
    add_item(8'h78, 1'b0);
    // An unterminated line closed by end of stream does not count as blank.
    add_fixed(8'h00, 1'b1, 3'd0, 32'h0);
    add_item(tslf_pkg::CH_NL, 1'b0);
    // Non-blank numbering with everything else off.
    add_reg(tslf_pkg::REG_NUMBERING, tslf_pkg::MODE_NONBLANK);
    add_reg(tslf_pkg::REG_CARET, 2'd0);
    add_reg(tslf_pkg::REG_TABS, 2'd0);
    add_reg(tslf_pkg::REG_LINE_ENDS, 2'd0);
    add_reg(tslf_pkg::REG_SQUEEZE, 2'd0);
    add_item(tslf_pkg::CH_TAB, 1'b0);
    add_fixed(tslf_pkg::CH_NL, 1'b0, 3'd1, {24'h0, tslf_pkg::CH_NL});
    add_fixed(tslf_pkg::CH_NL, 1'b0, 3'd1, {24'h0, tslf_pkg::CH_NL});
    // Unused numbering mode; caret on leaves a raw tab alone.
    add_reg(tslf_pkg::REG_NUMBERING, 2'd3);
    add_reg(tslf_pkg::REG_CARET, 2'd1);
    add_fixed(tslf_pkg::CH_TAB, 1'b0, 3'd1, {24'h0, tslf_pkg::CH_TAB});
    add_fixed(8'h8A, 1'b0, 3'd4,
              {8'h4A, tslf_pkg::CH_CARET, tslf_pkg::CH_DASH, tslf_pkg::CH_M});
    // A write to an unknown index changes nothing; a 1-bit register keeps bit 0.
    add_reg(3'd5, 2'd3);
    add_reg(tslf_pkg::REG_LINE_ENDS, 2'd2);
    add_fixed(8'h41, 1'b0, 3'd1, {24'h0, 8'h41});
    add_fixed(tslf_pkg::CH_NL, 1'b0, 3'd1, {24'h0, tslf_pkg::CH_NL});

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table.
    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_REG) begin
        drain();
        write_reg(row.idx, row.val);
      end else begin
        send_item(row.data, row.eos, row.fixed, row.fixed_n, row.fixed_bytes);
      end
    end

    // Random text in phases, each with its own settings and idling.
    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p % 4)
        0: begin src_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin src_idle_pct = 45; rcv_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  rcv_stall_pct = 45; end
        default: begin src_idle_pct = 36; rcv_stall_pct = 36; end
      endcase
      case (p)
        0: set_all(tslf_pkg::MODE_NONBLANK, 2'd1, 2'd1, 2'd1, 2'd1);
        1: set_all(2'd0, 2'd0, 2'd0, 2'd0, 2'd0);
        2: set_all(tslf_pkg::MODE_ALL, 2'd1, 2'd1, 2'd1, 2'd1);
        3: set_all(2'd3, 2'd3, 2'd3, 2'd3, 2'd3);
        default: set_all(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                         2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                         2'($urandom_range(0, 3)));
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        eos = 1'b0;
        if (r < 38) b = 8'($urandom_range(tslf_pkg::CH_SPACE, tslf_pkg::CH_DEL - 1));
        else if (r < 62) b = tslf_pkg::CH_NL;
        else if (r < 68) b = tslf_pkg::CH_TAB;
        else if (r < 76) b = 8'($urandom_range(0, tslf_pkg::CH_CTRL_END - 1));
        else if (r < 85) b = 8'($urandom_range(8'h80, 8'hFF));
        else if (r < 88) b = tslf_pkg::CH_DEL;
        else if (r < 93) begin
          b = 8'($urandom);
          eos = 1'b1;
        end else begin
          b = 8'($urandom);
        end
        send_item(b, eos, 1'b0, 3'd0, 32'h0);
      end
    end

    drain();

    $display("%0d input items sent, %0d output items checked, %0d directed rows",
             items_sent, bytes_checked, plan.size());
    $display("%0d random phases with changing settings and idling, %0d lines numbered",
             PHASES, line_no[0] + 10 * line_no[1] + 100 * line_no[2]);
    if (mismatches == 0 && pending_out.size() == 0) begin
      $display("tb_text_stream_line_formatter_top: PASS");
    end else begin
      $display("%0d mismatches, %0d output items never arrived", mismatches, pending_out.size());
      $display("tb_text_stream_line_formatter_top: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/tslf_pkg.sv
rtl/tslf_front.sv
rtl/tslf_queue.sv
rtl/tslf_back.sv
rtl/text_stream_line_formatter_top.sv
verif/tb_text_stream_line_formatter_top.sv
